// ===== rtl/bbe_pkg.sv =====
// Shared types, constants and sizes of the box blur block.
// Depends on nothing; every other file of the block imports it.
package bbe_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;
  localparam int MAX_RADIUS = 10;

  localparam int STORE_ROWS = 2 * MAX_RADIUS + 2;
  localparam int W_W        = $clog2(MAX_WIDTH + 1);
  localparam int H_W        = $clog2(MAX_HEIGHT + 1);
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int ROW_W      = $clog2(MAX_HEIGHT);
  localparam int RAD_W      = $clog2(MAX_RADIUS + 1);
  localparam int RING_W     = $clog2(STORE_ROWS);
  localparam int ADDR_W     = RING_W + COL_W;
  localparam int MUL_W      = (W_W > H_W) ? W_W : H_W;
  localparam int N_W        = 2 * MUL_W;
  localparam int TAP_W      = $clog2(2 * MAX_RADIUS + 1);
  localparam int CNT_W      = $clog2((2 * MAX_RADIUS + 1) * (2 * MAX_RADIUS + 1) + 1);
  localparam int SUM_W      = $clog2(255 * (2 * MAX_RADIUS + 1) * (2 * MAX_RADIUS + 1) + 1);
  localparam int DCNT_W     = $clog2(SUM_W);
  localparam int PIX_W      = 24;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 11;
  localparam int RADIUS_W   = 4;

  localparam logic [CFG_IDX_W-1:0] CFG_RADIUS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd2;

  localparam logic [RADIUS_W-1:0]   RADIUS_RST = 4'd0;
  localparam logic [CFG_DATA_W-1:0] WIDTH_RST  = 11'd500;
  localparam logic [CFG_DATA_W-1:0] HEIGHT_RST = 11'd500;

  localparam logic REQ_PIXEL = 1'b0;
  localparam logic REQ_FLUSH = 1'b1;

  typedef enum logic [1:0] {F_IDLE, F_WAIT, F_MUL, F_CHK} front_state_e;
  typedef enum logic [2:0] {B_IDLE, B_TAP, B_DRAIN, B_DIV, B_OUT} back_state_e;

  typedef struct packed {
    logic [RAD_W-1:0] r;
    logic [W_W-1:0]   w;
    logic [H_W-1:0]   h;
  } cfg_t;

  typedef struct packed {
    logic [ROW_W-1:0]  row;
    logic [COL_W-1:0]  col;
    logic [RING_W-1:0] ring;
    logic              done;
  } job_t;

  typedef struct packed {
    logic              en;
    logic [RING_W-1:0] ring;
    logic [COL_W-1:0]  col;
    logic [PIX_W-1:0]  pix;
  } wr_t;

endpackage

// ===== rtl/bbe_job_fifo.sv =====
// Two-entry queue of output jobs between the front and the back.
// Depends on bbe_pkg for the job type.
module bbe_job_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  bbe_pkg::job_t job_i,
  input  logic          pop_i,
  output bbe_pkg::job_t head_o,
  output logic          empty_o,
  output logic          full_o
);
  import bbe_pkg::*;

  job_t       slot_q [2];
  logic       wptr_q, rptr_q;
  logic [1:0] cnt_q;

  always_ff @(posedge clk_i) begin
    if (push_i) slot_q[wptr_q] <= job_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (push_i) wptr_q <= ~wptr_q;
      if (pop_i) rptr_q <= ~rptr_q;
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

  assign head_o  = slot_q[rptr_q];
  assign empty_o = (cnt_q == 2'd0);
  assign full_o  = (cnt_q == 2'd2);

endmodule

// ===== rtl/bbe_front.sv =====
// Front: configuration registers, request intake, position tracking and job issue.
// Depends on bbe_pkg; feeds the line store write port and the job queue.
module bbe_front (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [bbe_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [bbe_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic                           req_type_i,
  input  logic [7:0]                     blue_in_i,
  input  logic [7:0]                     green_in_i,
  input  logic [7:0]                     red_in_i,
  input  logic                           fifo_full_i,
  input  logic                           fifo_empty_i,
  input  logic                           back_busy_i,
  output bbe_pkg::cfg_t                  cfg_o,
  output bbe_pkg::wr_t                   wr_o,
  output logic                           push_o,
  output bbe_pkg::job_t                  job_o
);
  import bbe_pkg::*;

  front_state_e st_q, st_d;
  logic                  type_q;
  logic [PIX_W-1:0]      pix_q;
  logic [RADIUS_W-1:0]   radius_q;
  logic [CFG_DATA_W-1:0] width_q, height_q;
  logic [COL_W-1:0]  ic_q, ic_d, oc_q, oc_d;
  logic [H_W-1:0]    ir_q, ir_d;
  logic [ROW_W-1:0]  or_q, or_d;
  logic [RING_W-1:0] iring_q, iring_d, oring_q, oring_d;
  logic [1:0]        mstep_q, mstep_d;
  logic [N_W-1:0]    n_q, oi_q, lag_q, tot_q;
  logic [N_W-1:0]    prod;
  logic [MUL_W-1:0]  ma, mb, mc;
  cfg_t              cfg;
  logic              restart, bad, emit;
  logic [N_W-1:0]    n_e, oi_e, nw, nh;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg.r = (radius_q > RADIUS_W'(MAX_RADIUS)) ? RAD_W'(MAX_RADIUS) : RAD_W'(radius_q);
    if (width_q == '0) cfg.w = W_W'(1);
    else if (32'(width_q) > 32'(MAX_WIDTH)) cfg.w = W_W'(MAX_WIDTH);
    else cfg.w = W_W'(width_q);
    if (height_q == '0) cfg.h = H_W'(1);
    else if (32'(height_q) > 32'(MAX_HEIGHT)) cfg.h = H_W'(MAX_HEIGHT);
    else cfg.h = H_W'(height_q);
  end
  assign cfg_o = cfg;
  assign nw = N_W'(cfg.w);
  assign nh = N_W'(cfg.h);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q <= RADIUS_RST;
      width_q  <= WIDTH_RST;
      height_q <= HEIGHT_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_RADIUS: radius_q <= cfg_data_i[RADIUS_W-1:0];
        CFG_WIDTH:  width_q  <= cfg_data_i;
        CFG_HEIGHT: height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (mstep_q)
      2'd0: begin ma = MUL_W'(ir_q); mb = MUL_W'(cfg.w); mc = MUL_W'(ic_q); end
      2'd1: begin ma = MUL_W'(or_q); mb = MUL_W'(cfg.w); mc = MUL_W'(oc_q); end
      2'd2: begin ma = MUL_W'(cfg.r); mb = MUL_W'(cfg.w); mc = MUL_W'(cfg.r); end
      default: begin ma = MUL_W'(cfg.w); mb = MUL_W'(cfg.h); mc = '0; end
    endcase
    prod = N_W'(ma) * N_W'(mb) + N_W'(mc);
  end

  always_comb begin
    st_d    = st_q;
    mstep_d = mstep_q;
    ic_d    = ic_q;
    ir_d    = ir_q;
    oc_d    = oc_q;
    or_d    = or_q;
    iring_d = iring_q;
    oring_d = oring_q;
    in_ready_o = 1'b0;
    push_o  = 1'b0;
    emit    = 1'b0;
    wr_o    = '0;
    job_o   = '0;
    bad = (N_W'(ic_q) >= nw) || (N_W'(ir_q) > nh) ||
          ((N_W'(ir_q) == nh) && (ic_q != '0)) ||
          (N_W'(oc_q) >= nw) || (N_W'(or_q) >= nh);
    if (bad) restart = 1'b1;
    else if (N_W'(ir_q) < nh) restart = (oi_q != ((n_q >= lag_q) ? n_q - lag_q : '0));
    else restart = ({1'b0, oi_q} + {1'b0, lag_q}) < {1'b0, tot_q};
    n_e  = restart ? '0 : n_q;
    oi_e = restart ? '0 : oi_q;
    unique case (st_q)
      F_IDLE: begin
        in_ready_o = !fifo_full_i;
        if (in_valid_i && !fifo_full_i) st_d = F_WAIT;
      end
      F_WAIT: begin
        mstep_d = 2'd0;
        if (type_q == REQ_FLUSH || (!back_busy_i && fifo_empty_i)) st_d = F_MUL;
      end
      F_MUL: begin
        mstep_d = mstep_q + 2'd1;
        if (mstep_q == 2'd3) st_d = F_CHK;
      end
      F_CHK: begin
        st_d = F_IDLE;
        if (restart) begin
          ic_d = '0; ir_d = '0; oc_d = '0; or_d = '0; iring_d = '0; oring_d = '0;
        end
        if (type_q == REQ_PIXEL) begin
          if (N_W'(ir_d) < nh) begin
            wr_o.en   = 1'b1;
            wr_o.ring = iring_d;
            wr_o.col  = ic_d;
            wr_o.pix  = pix_q;
            if (N_W'(ic_d) + 1 >= nw) begin
              ic_d    = '0;
              ir_d    = ir_d + 1'b1;
              iring_d = (iring_d == RING_W'(STORE_ROWS - 1)) ? '0 : iring_d + 1'b1;
            end else begin
              ic_d = ic_d + 1'b1;
            end
            emit = ({1'b0, oi_e} + {1'b0, lag_q}) <= {1'b0, n_e};
          end
        end else begin
          emit = (N_W'(ir_d) >= nh) && (N_W'(or_d) < nh);
        end
        if (emit) begin
          push_o     = 1'b1;
          job_o.row  = or_d;
          job_o.col  = oc_d;
          job_o.ring = oring_d;
          if (N_W'(oc_d) + 1 >= nw) begin
            oc_d = '0;
            job_o.done = (N_W'(or_d) + 1 >= nh);
            or_d = or_d + 1'b1;
            oring_d = (oring_d == RING_W'(STORE_ROWS - 1)) ? '0 : oring_d + 1'b1;
          end else begin
            oc_d = oc_d + 1'b1;
          end
          if (job_o.done) begin
            ic_d = '0; ir_d = '0; oc_d = '0; or_d = '0; iring_d = '0; oring_d = '0;
          end
        end
      end
      default: st_d = F_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (st_q == F_IDLE && in_valid_i && !fifo_full_i) begin
      type_q <= req_type_i;
      pix_q  <= {red_in_i, green_in_i, blue_in_i};
    end
    if (st_q == F_MUL) begin
      unique case (mstep_q)
        2'd0: n_q   <= prod;
        2'd1: oi_q  <= prod;
        2'd2: lag_q <= prod;
        default: tot_q <= prod;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q    <= F_IDLE;
      mstep_q <= 2'd0;
      ic_q    <= '0;
      ir_q    <= '0;
      oc_q    <= '0;
      or_q    <= '0;
      iring_q <= '0;
      oring_q <= '0;
    end else begin
      st_q    <= st_d;
      mstep_q <= mstep_d;
      ic_q    <= ic_d;
      ir_q    <= ir_d;
      oc_q    <= oc_d;
      or_q    <= or_d;
      iring_q <= iring_d;
      oring_q <= oring_d;
    end
  end

endmodule

// ===== rtl/bbe_back.sv =====
// Back: line store, window sweep with edge clamping, serial divide and result register.
// Depends on bbe_pkg; takes jobs from the queue and store writes from the front.
module bbe_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  bbe_pkg::cfg_t cfg_i,
  input  bbe_pkg::wr_t  wr_i,
  input  bbe_pkg::job_t head_i,
  input  logic          fifo_empty_i,
  output logic          pop_o,
  output logic          busy_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output logic [7:0]    blue_out_o,
  output logic [7:0]    green_out_o,
  output logic [7:0]    red_out_o,
  output logic          frame_done_o
);
  import bbe_pkg::*;

  localparam int STORE_DEPTH = STORE_ROWS << COL_W;

  logic [PIX_W-1:0] mem [STORE_DEPTH];
  logic [PIX_W-1:0] rd_data_q;
  logic             rd_vld_q, rd_vld_d;
  logic [ADDR_W-1:0] rd_addr;

  back_state_e st_q, st_d;
  logic              done_q, done_d;
  logic [ROW_W-1:0]  y_q, y_d;
  logic [RING_W-1:0] ring_q, ring_d;
  logic [COL_W-1:0]  x_q, x_d, xs_q, xs_d;
  logic [TAP_W-1:0]  dxc_q, dxc_d, dyc_q, dyc_d, span;
  logic [TAP_W-1:0]  xk_q, xk_d, xk0_q, xk0_d, yk_q, yk_d;
  logic [DCNT_W-1:0] dcnt_q, dcnt_d;
  logic [SUM_W-1:0]  sum_q [3];
  logic [SUM_W-1:0]  sum_d [3];
  logic [CNT_W-1:0]  rem_q [3];
  logic [CNT_W-1:0]  rem_d [3];
  logic [CNT_W:0]    trial [3];
  logic [CNT_W-1:0]  side, divisor;
  logic              ov_q, ov_d;
  logic [7:0]        ob_q, og_q, or_q;
  logic              od_q, load;

  assign span    = TAP_W'({cfg_i.r, 1'b0});
  assign side    = CNT_W'(span) + 1'b1;
  assign divisor = side * side;
  assign rd_addr = {ring_q, x_q};

  always_ff @(posedge clk_i) begin
    if (wr_i.en) mem[{wr_i.ring, wr_i.col}] <= wr_i.pix;
    rd_data_q <= mem[rd_addr];
  end

  always_comb begin
    st_d   = st_q;
    done_d = done_q;
    y_d    = y_q;
    ring_d = ring_q;
    x_d    = x_q;
    xs_d   = xs_q;
    xk_d   = xk_q;
    xk0_d  = xk0_q;
    yk_d   = yk_q;
    dxc_d  = dxc_q;
    dyc_d  = dyc_q;
    dcnt_d = dcnt_q;
    rd_vld_d = 1'b0;
    pop_o  = 1'b0;
    load   = 1'b0;
    for (int c = 0; c < 3; c++) begin
      sum_d[c] = sum_q[c];
      rem_d[c] = rem_q[c];
      trial[c] = {rem_q[c], sum_q[c][SUM_W-1]};
    end
    if (rd_vld_q) begin
      for (int c = 0; c < 3; c++) sum_d[c] = sum_q[c] + SUM_W'(rd_data_q[8*c +: 8]);
    end
    unique case (st_q)
      B_IDLE: begin
        if (!fifo_empty_i) begin
          pop_o  = 1'b1;
          done_d = head_i.done;
          if (32'(head_i.row) >= 32'(cfg_i.r)) begin
            y_d = head_i.row - ROW_W'(cfg_i.r);
            ring_d = (32'(head_i.ring) >= 32'(cfg_i.r)) ? head_i.ring - RING_W'(cfg_i.r)
                   : head_i.ring + RING_W'(STORE_ROWS) - RING_W'(cfg_i.r);
            yk_d = '0;
          end else begin
            y_d = '0;
            ring_d = '0;
            yk_d = TAP_W'(cfg_i.r) - TAP_W'(head_i.row);
          end
          if (32'(head_i.col) >= 32'(cfg_i.r)) begin
            x_d   = head_i.col - COL_W'(cfg_i.r);
            xk0_d = '0;
          end else begin
            x_d   = '0;
            xk0_d = TAP_W'(cfg_i.r) - TAP_W'(head_i.col);
          end
          xk_d  = xk0_d;
          xs_d  = x_d;
          dxc_d = '0;
          dyc_d = '0;
          for (int c = 0; c < 3; c++) sum_d[c] = '0;
          st_d = B_TAP;
        end
      end
      B_TAP: begin
        rd_vld_d = 1'b1;
        if (dxc_q == span) begin
          dxc_d = '0;
          x_d   = xs_q;
          xk_d  = xk0_q;
          if (dyc_q == span) begin
            st_d = B_DRAIN;
          end else begin
            dyc_d = dyc_q + 1'b1;
            if (yk_q != '0) begin
              yk_d = yk_q - 1'b1;
            end else if (N_W'(y_q) + 1 < N_W'(cfg_i.h)) begin
              y_d = y_q + 1'b1;
              ring_d = (ring_q == RING_W'(STORE_ROWS - 1)) ? '0 : ring_q + 1'b1;
            end
          end
        end else begin
          dxc_d = dxc_q + 1'b1;
          if (xk_q != '0) xk_d = xk_q - 1'b1;
          else if (N_W'(x_q) + 1 < N_W'(cfg_i.w)) x_d = x_q + 1'b1;
        end
      end
      B_DRAIN: begin
        dcnt_d = '0;
        for (int c = 0; c < 3; c++) rem_d[c] = '0;
        st_d = B_DIV;
      end
      B_DIV: begin
        for (int c = 0; c < 3; c++) begin
          if (trial[c] >= {1'b0, divisor}) begin
            rem_d[c] = CNT_W'(trial[c] - {1'b0, divisor});
            sum_d[c] = {sum_q[c][SUM_W-2:0], 1'b1};
          end else begin
            rem_d[c] = trial[c][CNT_W-1:0];
            sum_d[c] = {sum_q[c][SUM_W-2:0], 1'b0};
          end
        end
        dcnt_d = dcnt_q + 1'b1;
        if (dcnt_q == DCNT_W'(SUM_W - 1)) st_d = B_OUT;
      end
      B_OUT: begin
        if (!ov_q || out_ready_i) begin
          load = 1'b1;
          st_d = B_IDLE;
        end
      end
      default: st_d = B_IDLE;
    endcase
    ov_d = load ? 1'b1 : (ov_q && !out_ready_i);
  end

  always_ff @(posedge clk_i) begin
    done_q <= done_d;
    y_q    <= y_d;
    ring_q <= ring_d;
    x_q    <= x_d;
    xs_q   <= xs_d;
    xk_q   <= xk_d;
    xk0_q  <= xk0_d;
    yk_q   <= yk_d;
    dxc_q  <= dxc_d;
    dyc_q  <= dyc_d;
    dcnt_q <= dcnt_d;
    for (int c = 0; c < 3; c++) begin
      sum_q[c] <= sum_d[c];
      rem_q[c] <= rem_d[c];
    end
    if (load) begin
      ob_q <= sum_q[0][7:0];
      og_q <= sum_q[1][7:0];
      or_q <= sum_q[2][7:0];
      od_q <= done_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q     <= B_IDLE;
      rd_vld_q <= 1'b0;
      ov_q     <= 1'b0;
    end else begin
      st_q     <= st_d;
      rd_vld_q <= rd_vld_d;
      ov_q     <= ov_d;
    end
  end

  assign busy_o       = (st_q != B_IDLE);
  assign out_valid_o  = ov_q;
  assign blue_out_o   = ob_q;
  assign green_out_o  = og_q;
  assign red_out_o    = or_q;
  assign frame_done_o = od_q;

`ifndef ASSERT_OFF
  a_rd_after_tap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_vld_q |-> $past(st_q == B_TAP))
    else $error("store read without a window tap");
  a_pop_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |-> (st_q == B_IDLE) && !fifo_empty_i)
    else $error("job taken while busy");
  a_wr_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_i.en |-> (st_q == B_IDLE) && fifo_empty_i)
    else $error("store written during a window sweep");
`endif

endmodule

// ===== rtl/box_blur_edge_clamped_unit.sv =====
// Channel   | direction | handshake             | payload
// cfg       | in        | cfg_valid_i/ready_o   | cfg_index_i, cfg_data_i
// in        | in        | in_valid_i/in_ready_o | req_type_i, blue/green/red_in_i
// out       | out       | out_valid_o/ready_i   | blue/green/red_out_o, frame_done_o
// In the front a request goes through accept, wait, four multiply steps and check.
// A pixel waits in the front until the back is idle and the job queue empty.
// A result in the back goes through job pick-up, the store reads of its window,
// a serial divide and the hand-off.
// Reset clears positions and queue; the line store is not cleared.
// The output register lets the back finish one result while the previous one stalls.
// Top level: ties the front, the job queue and the back together. Depends on bbe_pkg.
module box_blur_edge_clamped_unit (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [bbe_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [bbe_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic                           req_type_i,
  input  logic [7:0]                     blue_in_i,
  input  logic [7:0]                     green_in_i,
  input  logic [7:0]                     red_in_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [7:0]                     blue_out_o,
  output logic [7:0]                     green_out_o,
  output logic [7:0]                     red_out_o,
  output logic                           frame_done_o
);
  import bbe_pkg::*;

  cfg_t cfg;
  wr_t  wr;
  job_t job, head;
  logic push, pop, empty, full, busy;

  bbe_front u_front (
    .clk_i, .rst_ni,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i,
    .in_valid_i, .in_ready_o, .req_type_i, .blue_in_i, .green_in_i, .red_in_i,
    .fifo_full_i(full), .fifo_empty_i(empty), .back_busy_i(busy),
    .cfg_o(cfg), .wr_o(wr), .push_o(push), .job_o(job)
  );

  bbe_job_fifo u_fifo (
    .clk_i, .rst_ni,
    .push_i(push), .job_i(job), .pop_i(pop),
    .head_o(head), .empty_o(empty), .full_o(full)
  );

  bbe_back u_back (
    .clk_i, .rst_ni,
    .cfg_i(cfg), .wr_i(wr), .head_i(head), .fifo_empty_i(empty),
    .pop_o(pop), .busy_o(busy),
    .out_valid_o, .out_ready_i, .blue_out_o, .green_out_o, .red_out_o, .frame_done_o
  );

endmodule

// ===== test/tb.sv =====
// Self-checking testbench for box_blur_edge_clamped_unit: drives pixel and flush
// requests, predicts each blurred output pixel and compares them field by field.
// Depends on bbe_pkg and the RTL of the block.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import bbe_pkg::*;

  localparam int LIMIT   = 3000000;
  localparam int SETTLE  = 700;
  localparam int HOLDOFF = 3000;

  typedef struct {
    logic       kind;
    logic [7:0] b, g, r;
  } blur_req_t;

  typedef struct {
    logic [7:0] b, g, r;
    logic       done;
  } blur_pix_t;

  logic clk = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_RADIUS;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic req_type = REQ_PIXEL;
  logic [7:0] blue_in = '0, green_in = '0, red_in = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [7:0] blue_out, green_out, red_out;
  logic frame_done;

  blur_req_t req_q[$];
  blur_pix_t pix_q[$];
  int        cycles = 0;
  int        errors = 0;
  bit        gaps_on = 1'b1;
  bit        hold_go = 1'b0;
  logic      hold = 1'b0;
  int        in_gap = 0, out_gap = 0;

  // predictor state
  logic [23:0] line_mem [0:STORE_ROWS*MAX_WIDTH-1];
  int rad_reg = 0, wid_reg = 500, hgt_reg = 500;
  int in_col = 0, in_row = 0, out_col = 0, out_row = 0;

  box_blur_edge_clamped_unit dut (
    .clk_i(clk), .rst_ni(rst_ni),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data),
    .in_valid_i(in_valid), .in_ready_o(in_ready),
    .req_type_i(req_type), .blue_in_i(blue_in), .green_in_i(green_in), .red_in_i(red_in),
    .out_valid_o(out_valid), .out_ready_i(out_ready),
    .blue_out_o(blue_out), .green_out_o(green_out), .red_out_o(red_out),
    .frame_done_o(frame_done)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic int eff_w();
    return wid_reg < 1 ? 1 : (wid_reg > MAX_WIDTH ? MAX_WIDTH : wid_reg);
  endfunction

  function automatic int eff_h();
    return hgt_reg < 1 ? 1 : (hgt_reg > MAX_HEIGHT ? MAX_HEIGHT : hgt_reg);
  endfunction

  function automatic int eff_r();
    return rad_reg > MAX_RADIUS ? MAX_RADIUS : rad_reg;
  endfunction

  function automatic int clip(int v, int hi);
    return v < 0 ? 0 : (v > hi ? hi : v);
  endfunction

  function automatic void restart_frame();
    in_col = 0;
    in_row = 0;
    out_col = 0;
    out_row = 0;
  endfunction

  function automatic blur_pix_t window_mean(int w, int h, int r);
    blur_pix_t px;
    int sb, sg, sr, cnt, y, x;
    logic [23:0] p;
    sb = 0;
    sg = 0;
    sr = 0;
    cnt = (2*r+1) * (2*r+1);
    for (int dy = -r; dy <= r; dy++) begin
      y = clip(out_row + dy, h - 1);
      for (int dx = -r; dx <= r; dx++) begin
        x = clip(out_col + dx, w - 1);
        p = line_mem[(y % STORE_ROWS) * MAX_WIDTH + x];
        sb += p[7:0];
        sg += p[15:8];
        sr += p[23:16];
      end
    end
    px.b = 8'(sb / cnt);
    px.g = 8'(sg / cnt);
    px.r = 8'(sr / cnt);
    px.done = 1'b0;
    out_col++;
    if (out_col >= w) begin
      out_col = 0;
      out_row++;
    end
    if (out_row >= h) begin
      px.done = 1'b1;
      restart_frame();
    end
    return px;
  endfunction

  function automatic void blur_step(blur_req_t rq);
    int w, h, r, lag, total, n, oi;
    w = eff_w();
    h = eff_h();
    r = eff_r();
    lag = r * w + r;
    total = w * h;
    if (in_col >= w || in_row > h || (in_row == h && in_col != 0) ||
        out_col >= w || out_row >= h) begin
      restart_frame();
    end else begin
      n = in_row * w + in_col;
      oi = out_row * w + out_col;
      if (in_row < h) begin
        if (oi != (n >= lag ? n - lag : 0)) restart_frame();
      end else if (oi + lag < total) begin
        restart_frame();
      end
    end
    if (rq.kind == REQ_PIXEL) begin
      if (in_row >= h) return;
      line_mem[(in_row % STORE_ROWS) * MAX_WIDTH + in_col] = {rq.r, rq.g, rq.b};
      n = in_row * w + in_col;
      in_col++;
      if (in_col >= w) begin
        in_col = 0;
        in_row++;
      end
      if (out_row * w + out_col + lag <= n) pix_q.push_back(window_mean(w, h, r));
    end else if (in_row >= h && out_row < h) begin
      pix_q.push_back(window_mean(w, h, r));
    end
  endfunction

  function automatic int pick_gap();
    int k;
    if (!gaps_on) return 0;
    k = $urandom_range(0, 99);
    if (k < 55) return 0;
    if (k < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // request driver
  always @(posedge clk) begin
    if (rst_ni) begin
      if (in_valid && in_ready) begin
        blur_step(req_q.pop_front());
        in_gap = pick_gap();
      end
      if (!in_valid || in_ready) begin
        if (in_gap > 0 || req_q.size() == 0) begin
          if (in_gap > 0) in_gap--;
          in_valid <= 1'b0;
        end else begin
          in_valid <= 1'b1;
          req_type <= req_q[0].kind;
          blue_in  <= req_q[0].b;
          green_in <= req_q[0].g;
          red_in   <= req_q[0].r;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    blur_pix_t want;
    if (rst_ni) begin
      if (out_valid && out_ready) begin
        if (pix_q.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected output pixel %h %h %h done %b",
                                     blue_out, green_out, red_out, frame_done);
        end else begin
          want = pix_q.pop_front();
          if (want.b !== blue_out || want.g !== green_out || want.r !== red_out ||
              want.done !== frame_done) begin
            errors++;
            if (errors <= 10)
              $display("pixel mismatch: exp b%h g%h r%h d%b, got b%h g%h r%h d%b",
                       want.b, want.g, want.r, want.done,
                       blue_out, green_out, red_out, frame_done);
          end
        end
      end
      if (out_gap > 0) out_gap--;
      else if (gaps_on) out_gap = pick_gap();
      out_ready <= !hold && out_gap == 0;
    end
  end

  initial begin
    wait (hold_go);
    @(posedge clk) hold <= 1'b1;
    repeat (HOLDOFF) @(posedge clk);
    hold <= 1'b0;
  end

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, int value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= CFG_DATA_W'(value);
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_RADIUS: rad_reg = value & 15;
      CFG_WIDTH:  wid_reg = value & 2047;
      default:    hgt_reg = value & 2047;
    endcase
    cfg_valid <= 1'b0;
  endtask

  task automatic set_frame(int r, int w, int h);
    cfg_write(CFG_RADIUS, r);
    cfg_write(CFG_WIDTH, w);
    cfg_write(CFG_HEIGHT, h);
  endtask

  task automatic push_req(logic kind, logic [7:0] b, logic [7:0] g, logic [7:0] r);
    blur_req_t rq;
    rq.kind = kind;
    rq.b = b;
    rq.g = g;
    rq.r = r;
    req_q.push_back(rq);
  endtask

  task automatic push_rand_pixel();
    push_req(REQ_PIXEL, 8'($urandom), 8'($urandom), 8'($urandom));
  endtask

  // one full frame at the current setting; returns the number of pixels in the frame
  task automatic push_frame(int noise, output int sent);
    int w, h, r, total, lag, drain;
    w = eff_w();
    h = eff_h();
    r = eff_r();
    total = w * h;
    lag = r * w + r;
    drain = total >= lag ? lag : total;
    for (int i = 0; i < total; i++) begin
      if (noise && $urandom_range(0, 19) == 0) push_req(REQ_FLUSH, 8'($urandom), 8'hA5, 8'h5A);
      push_rand_pixel();
    end
    for (int i = 0; i < drain; i++) begin
      if (noise && $urandom_range(0, 9) == 0) push_rand_pixel();
      push_req(REQ_FLUSH, 8'($urandom), 8'($urandom), 8'($urandom));
    end
    if (noise && $urandom_range(0, 4) == 0) push_req(REQ_FLUSH, 8'h00, 8'h00, 8'h00);
    sent = total;
  endtask

  task automatic settle();
    wait (req_q.size() == 0 && !in_valid && pix_q.size() == 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  initial begin
    int sent, done_items, r, w, h, k;
    repeat (5) @(posedge clk);
    rst_ni <= 1'b1;
    @(posedge clk);

    // single pixel frame, zero sizes clamp to one
    set_frame(0, 0, 0);
    push_req(REQ_PIXEL, 8'h00, 8'hFF, 8'h00);
    push_req(REQ_PIXEL, 8'hFF, 8'h00, 8'hFF);
    push_req(REQ_FLUSH, 8'hFF, 8'hFF, 8'hFF);
    settle();

    // radius above the maximum on a frame smaller than the lag
    set_frame(15, 3, 2);
    push_req(REQ_FLUSH, 8'h12, 8'h34, 8'h56);
    push_req(REQ_PIXEL, 8'hFF, 8'hFF, 8'hFF);
    push_req(REQ_PIXEL, 8'h00, 8'h00, 8'h00);
    push_req(REQ_PIXEL, 8'hFF, 8'h00, 8'h80);
    push_req(REQ_FLUSH, 8'h00, 8'h00, 8'h00);
    push_req(REQ_PIXEL, 8'h01, 8'hFE, 8'h7F);
    push_req(REQ_PIXEL, 8'hFF, 8'hFF, 8'hFF);
    push_req(REQ_PIXEL, 8'hFF, 8'hFF, 8'hFF);
    push_req(REQ_FLUSH, 8'h00, 8'h00, 8'h00);
    push_req(REQ_PIXEL, 8'hAA, 8'h55, 8'hAA);
    for (int i = 0; i < 5; i++) push_req(REQ_FLUSH, 8'h00, 8'h00, 8'h00);
    push_req(REQ_FLUSH, 8'h00, 8'h00, 8'h00);
    settle();

    // widest row, every pixel gives a result; the receiver holds off meanwhile
    set_frame(0, 2047, 1);
    hold_go = 1'b1;
    push_frame(0, sent);
    settle();

    done_items = 0;
    while (done_items < 200) begin
      k = $urandom_range(0, 99);
      if (k < 70) begin
        r = $urandom_range(0, 3);
        w = $urandom_range(1, 24);
        h = $urandom_range(1, 8);
      end else begin
        r = (k < 90) ? $urandom_range(4, 9) : $urandom_range(10, 15);
        w = $urandom_range(1, 4);
        h = $urandom_range(1, 3);
      end
      gaps_on = $urandom_range(0, 4) != 0;
      set_frame(r, w, h);
      repeat ($urandom_range(1, 3)) begin
        push_frame($urandom_range(0, 2) != 0, sent);
        done_items += sent;
      end
      settle();
    end

    if (errors == 0 && pix_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
